>>> rtl/core/brb_pkg.sv
`timescale 1ns / 1ps
// Package for the circular byte FIFO: sizes, request op codes and sequencer states.
// No dependencies; imported by the channel interfaces and the top level.
package brb_pkg;

	localparam int DEPTH     = 256;
	localparam int MAX_BURST = 8;

	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CAP_W  = $clog2(DEPTH) + 1;
	localparam int OP_W   = 3;
	localparam int LEN_W  = 4;
	localparam int DATA_W = 64;
	localparam int IDX_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_PUT_BYTE  = 3'd0,
		OP_GET_BYTE  = 3'd1,
		OP_PUT_BLOCK = 3'd2,
		OP_GET_BLOCK = 3'd3,
		OP_PUT_HEAD  = 3'd4
	} brb_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} brb_state_t;

endpackage

>>> rtl/core/brb_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the circular byte FIFO: request and response.
// Depends on brb_pkg for the field widths.
interface brb_req_if;
	import brb_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [LEN_W-1:0]  length;
	logic [DATA_W-1:0] write_bytes;

	modport source (output valid, output op, output length, output write_bytes, input ready);
	modport sink   (input valid, input op, input length, input write_bytes, output ready);
endinterface

interface brb_rsp_if;
	import brb_pkg::*;

	logic              valid;
	logic              ready;
	logic              ok;
	logic [LEN_W-1:0]  count;
	logic [DATA_W-1:0] read_bytes;
	logic [CAP_W-1:0]  level;

	modport source (output valid, output ok, output count, output read_bytes, output level,
		input ready);
	modport sink   (input valid, input ok, input count, input read_bytes, input level,
		output ready);
endinterface

>>> rtl/core/brb_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/byte_ring_buffer.sv
`timescale 1ns / 1ps
// Top level of the circular byte FIFO: request sequencer, pointers and result register.
// Depends on brb_pkg, brb_if (brb_req_if, brb_rsp_if) and brb_ram.
//
// Usage:
//   req  - request words: op, length and up to eight bytes in write_bytes (byte 0 in 7:0).
//   rsp  - one result word per request: ok, count, read_bytes (first byte in 7:0), level.
//   cfg_we / cfg_wdata - capacity register. A write empties the FIFO; write it only
//          while no request is in flight. Zero acts as one, values above DEPTH as DEPTH.
// Sequence:
//   The store is a byte-wide RAM, so a request moving n bytes (0 to 8) makes one RAM
//   access per byte in ST_RUN, then closes there while the last read byte lands, and
//   then loads the result register in ST_FIN. req.ready rises together with the result
//   valid, so the next request is accepted only once the previous result is loaded.
// Reset:
//   arst_n clears pointers and fill level and sets the capacity to DEPTH. The store
//   itself is not cleared; reads only ever reach slots written before.
// Stalls:
//   The result register holds a finished result until rsp.ready. The next request is
//   still taken and worked; it then waits in ST_FIN until the register frees.
module byte_ring_buffer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [brb_pkg::CAP_W-1:0] cfg_wdata,
	brb_req_if.sink                   req,
	brb_rsp_if.source                 rsp
);
	import brb_pkg::*;

	brb_state_t state_q, state_d;

	logic [CAP_W-1:0]  cap_q;
	logic [CAP_W-1:0]  occ_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;

	// request context
	logic              dir_rd_q;
	logic              ok_q;
	logic [LEN_W-1:0]  n_q;
	logic [LEN_W-1:0]  idx_q;
	logic [DATA_W-1:0] wb_q;
	logic [DATA_W-1:0] rb_q;

	// read return tracking
	logic              rd_pend_s1;
	logic [IDX_W-1:0]  rd_idx_s1;

	// result register
	logic              out_valid_q;
	logic              out_ok_q;
	logic [LEN_W-1:0]  out_count_q;
	logic [DATA_W-1:0] out_rb_q;
	logic [CAP_W-1:0]  out_level_q;

	// decode of an incoming request
	logic [CAP_W-1:0]  free_w;
	logic [CAP_W-1:0]  len_w;
	logic              len_ok;
	logic              dec_ok;
	logic              dec_rd;
	logic [LEN_W-1:0]  dec_n;

	// sequencer outputs
	logic              accept;
	logic              step;
	logic              load_out;
	logic              ram_we;
	logic              ram_re;

	// shared pointer unit
	logic [PTR_W-1:0]  ptr_sel;
	logic [CAP_W-1:0]  ptr_inc;
	logic [PTR_W-1:0]  ptr_nxt;

	logic [CAP_W-1:0]  cap_eff;
	logic [7:0]        ram_rdata;

	// Clamp a capacity write into 1..DEPTH.
	always_comb begin
		if (cfg_wdata == '0) begin
			cap_eff = CAP_W'(1);
		end else if (cfg_wdata > CAP_W'(DEPTH)) begin
			cap_eff = CAP_W'(DEPTH);
		end else begin
			cap_eff = cfg_wdata;
		end
	end

	// Decide direction and byte count from the current fill level.
	always_comb begin
		free_w = cap_q - occ_q;
		len_w  = CAP_W'(req.length);
		len_ok = (req.length <= LEN_W'(MAX_BURST));
		dec_ok = 1'b0;
		dec_rd = 1'b0;
		dec_n  = '0;
		case (req.op)
			OP_PUT_BYTE: begin
				dec_ok = (free_w != '0);
				dec_n  = dec_ok ? LEN_W'(1) : '0;
			end
			OP_GET_BYTE: begin
				dec_rd = 1'b1;
				dec_ok = (occ_q != '0);
				dec_n  = dec_ok ? LEN_W'(1) : '0;
			end
			OP_PUT_BLOCK: begin
				dec_ok = len_ok && (len_w <= free_w);
				dec_n  = dec_ok ? req.length : '0;
			end
			OP_GET_BLOCK: begin
				dec_rd = 1'b1;
				dec_ok = len_ok && (len_w <= occ_q);
				dec_n  = dec_ok ? req.length : '0;
			end
			OP_PUT_HEAD: begin
				// store what fits; count reports the bytes taken
				dec_ok = len_ok;
				if (!len_ok) begin
					dec_n = '0;
				end else if (len_w > free_w) begin
					dec_n = free_w[LEN_W-1:0];
				end else begin
					dec_n = req.length;
				end
			end
			default: begin
				dec_ok = 1'b0;
				dec_n  = '0;
			end
		endcase
	end

	// Shared pointer unit: advance whichever pointer this request walks, wrap at capacity.
	always_comb begin
		ptr_sel = dir_rd_q ? rd_ptr_q : wr_ptr_q;
		ptr_inc = CAP_W'(ptr_sel) + CAP_W'(1);
		ptr_nxt = (ptr_inc >= cap_q) ? '0 : ptr_inc[PTR_W-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (idx_q == n_q) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		accept    = req.valid && (state_q == ST_IDLE);
		step      = (state_q == ST_RUN) && (idx_q != n_q);
		ram_we    = step && !dir_rd_q;
		ram_re    = step && dir_rd_q;
		load_out  = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);
	end

	brb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (wb_q[{idx_q[IDX_W-1:0], 3'b000} +: 8]),
		.re    (ram_re),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cap_q      <= CAP_W'(DEPTH);
			occ_q      <= '0;
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			idx_q      <= '0;
			n_q        <= '0;
			rd_pend_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= ram_re;
			if (cfg_we) begin
				// new wrap point: empty the FIFO
				cap_q    <= cap_eff;
				occ_q    <= '0;
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
			end else if (step) begin
				idx_q <= idx_q + LEN_W'(1);
				if (dir_rd_q) begin
					rd_ptr_q <= ptr_nxt;
					occ_q    <= occ_q - CAP_W'(1);
				end else begin
					wr_ptr_q <= ptr_nxt;
					occ_q    <= occ_q + CAP_W'(1);
				end
			end
			if (accept) begin
				idx_q <= '0;
				n_q   <= dec_n;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			dir_rd_q <= dec_rd;
			ok_q     <= dec_ok;
			wb_q     <= req.write_bytes;
			rb_q     <= '0;
		end else if (rd_pend_s1) begin
			rb_q[{rd_idx_s1, 3'b000} +: 8] <= ram_rdata;
		end
		if (ram_re) begin
			rd_idx_s1 <= idx_q[IDX_W-1:0];
		end
		if (load_out) begin
			out_ok_q    <= ok_q;
			out_count_q <= n_q;
			out_rb_q    <= rb_q;
			out_level_q <= occ_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.ok         = out_ok_q;
	assign rsp.count      = out_count_q;
	assign rsp.read_bytes = out_rb_q;
	assign rsp.level      = out_level_q;

	// Byte walk never runs past the decided count.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> idx_q <= n_q)
		else $error("byte index past request count");

	// Fill level stays within the capacity.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= cap_q)
		else $error("fill level above capacity");

	// Both pointers stay below the wrap point.
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CAP_W'(rd_ptr_q) < cap_q && CAP_W'(wr_ptr_q) < cap_q)
		else $error("pointer beyond capacity");

	// Read data only comes back from a byte step of the sequencer.
	a_rd_return: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(state_q == ST_RUN) && dir_rd_q)
		else $error("read return outside a read walk");

	// An accepted request always enters the byte walk.
	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_RUN)
		else $error("accepted request did not start");

endmodule

>>> dv/tb_byte_ring_buffer.sv
`timescale 1ns / 1ps
// Self-checking testbench for byte_ring_buffer: a directed table, then random request words
// checked against an in-bench prediction of the ring. Depends on brb_pkg and brb_if.
module tb_byte_ring_buffer;
	import brb_pkg::*;

	localparam int LIMIT       = 400000;
	localparam int MAX_REPORTS = 100;
	localparam int N_PHASES    = 12;

	// Op codes that the block rejects with a failed, empty result.
	localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

	localparam logic [DATA_W-1:0] ONES = {DATA_W{1'b1}};

	typedef struct packed {
		logic              ok;
		logic [LEN_W-1:0]  count;
		logic [DATA_W-1:0] read_bytes;
		logic [CAP_W-1:0]  level;
	} fifo_result_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// One directed row: a request word, or a capacity write (value in wdata).
	// Where typed is set, res is the expected result; else the prediction is used.
	typedef struct packed {
		row_kind_t         kind;
		logic [OP_W-1:0]   op;
		logic [LEN_W-1:0]  length;
		logic [DATA_W-1:0] wdata;
		logic              typed;
		fifo_result_t      res;
	} stim_row_t;

	localparam fifo_result_t NONE = '0;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we;
	logic [CAP_W-1:0]  cfg_wdata;

	brb_req_if req_ch ();
	brb_rsp_if rsp_ch ();

	byte_ring_buffer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Directed part. Starts at the reset capacity of DEPTH.
	stim_row_t dir_tab [0:27] = '{
		// empty FIFO: byte get and block get fail, zero-length ops succeed
		'{ROW_REQ, OP_GET_BYTE,  4'd0,  64'd0, 1'b1, '{1'b0, 4'd0, 64'd0, 9'd0}},
		'{ROW_REQ, OP_GET_BLOCK, 4'd1,  64'd0, 1'b1, '{1'b0, 4'd0, 64'd0, 9'd0}},
		'{ROW_REQ, OP_GET_BLOCK, 4'd0,  64'd0, 1'b1, '{1'b1, 4'd0, 64'd0, 9'd0}},
		'{ROW_REQ, OP_PUT_BLOCK, 4'd0,  ONES,  1'b1, '{1'b1, 4'd0, 64'd0, 9'd0}},
		'{ROW_REQ, OP_PUT_HEAD,  4'd0,  ONES,  1'b1, '{1'b1, 4'd0, 64'd0, 9'd0}},
		// lengths above the burst limit are rejected, nothing moves
		'{ROW_REQ, OP_PUT_BLOCK, 4'd9,  ONES,  1'b1, '{1'b0, 4'd0, 64'd0, 9'd0}},
		'{ROW_REQ, OP_PUT_HEAD,  4'd15, ONES,  1'b1, '{1'b0, 4'd0, 64'd0, 9'd0}},
		// unknown op: rejected, nothing moves
		'{ROW_REQ, OP_RSVD_FIRST, 4'd8, ONES,  1'b1, '{1'b0, 4'd0, 64'd0, 9'd0}},
		// all-ones data in and out
		'{ROW_REQ, OP_PUT_BYTE,  4'd0,  ONES,  1'b1, '{1'b1, 4'd1, 64'd0, 9'd1}},
		'{ROW_REQ, OP_PUT_BLOCK, 4'd8,  ONES,  1'b1, '{1'b1, 4'd8, 64'd0, 9'd9}},
		'{ROW_REQ, OP_GET_BYTE,  4'd0,  64'd0, 1'b1, '{1'b1, 4'd1, 64'hFF, 9'd8}},
		'{ROW_REQ, OP_GET_BLOCK, 4'd8,  64'd0, 1'b1, '{1'b1, 4'd8, ONES, 9'd0}},
		// byte order through the ring
		'{ROW_REQ, OP_PUT_BLOCK, 4'd8,  64'h0706050403020100, 1'b0, NONE},
		'{ROW_REQ, OP_GET_BLOCK, 4'd3,  64'd0, 1'b0, NONE},
		'{ROW_REQ, OP_PUT_HEAD,  4'd8,  64'hA55A_C33C_F00F_9669, 1'b0, NONE},
		'{ROW_REQ, OP_GET_BLOCK, 4'd8,  64'd0, 1'b0, NONE},
		// capacity 4: block get checked against the fill level, not the capacity
		'{ROW_CFG, OP_PUT_BYTE,  4'd0,  64'd4, 1'b0, NONE},
		'{ROW_REQ, OP_PUT_BYTE,  4'd0,  64'h5A, 1'b1, '{1'b1, 4'd1, 64'd0, 9'd1}},
		'{ROW_REQ, OP_GET_BLOCK, 4'd3,  64'd0, 1'b1, '{1'b0, 4'd0, 64'd0, 9'd1}},
		// block put beyond free space, put-head clipped to free space, full byte put
		'{ROW_REQ, OP_PUT_BLOCK, 4'd4,  ONES,  1'b1, '{1'b0, 4'd0, 64'd0, 9'd1}},
		'{ROW_REQ, OP_PUT_HEAD,  4'd8,  64'h8877_6655_4433_2211, 1'b1,
			'{1'b1, 4'd3, 64'd0, 9'd4}},
		'{ROW_REQ, OP_PUT_BYTE,  4'd0,  ONES,  1'b1, '{1'b0, 4'd0, 64'd0, 9'd4}},
		'{ROW_REQ, OP_PUT_HEAD,  4'd1,  ONES,  1'b1, '{1'b1, 4'd0, 64'd0, 9'd4}},
		'{ROW_REQ, OP_GET_BLOCK, 4'd4,  64'd0, 1'b0, NONE},
		// capacity 0 acts as one slot
		'{ROW_CFG, OP_PUT_BYTE,  4'd0,  64'd0, 1'b0, NONE},
		'{ROW_REQ, OP_PUT_BYTE,  4'd0,  64'h3C, 1'b1, '{1'b1, 4'd1, 64'd0, 9'd1}},
		'{ROW_REQ, OP_PUT_BYTE,  4'd0,  64'hC3, 1'b1, '{1'b0, 4'd0, 64'd0, 9'd1}},
		'{ROW_REQ, OP_GET_BYTE,  4'd0,  64'd0, 1'b1, '{1'b1, 4'd1, 64'h3C, 9'd0}}
	};

	// Random phases: capacity and number of valid-op words. The last two capacities are
	// drawn at run time.
	int phase_cap   [N_PHASES] = '{256, 1, 0, 2, 3, 8, 9, 511, 300, 64, 0, 0};
	int phase_items [N_PHASES] = '{400, 60, 40, 60, 60, 80, 80, 250, 100, 120, 100, 100};

	// Ring prediction state.
	logic [7:0]       ring_mem [DEPTH];
	logic [CAP_W-1:0] cap_reg = CAP_W'(DEPTH);
	int               rd_ptr = 0;
	int               wr_ptr = 0;
	int               fill = 0;

	fifo_result_t     pending_q [$];
	fifo_result_t     head_res;
	int               err_cnt = 0;
	int               cycle_cnt = 0;
	int               tx_idle_pct = 18;
	int               rx_idle_pct = 50;

	function automatic int eff_capacity();
		if (cap_reg == '0)
			return 1;
		if (int'(cap_reg) > DEPTH)
			return DEPTH;
		return int'(cap_reg);
	endfunction

	function automatic void ring_push(logic [7:0] b, int cap);
		if (wr_ptr >= cap)
			wr_ptr = 0;
		ring_mem[wr_ptr] = b;
		wr_ptr++;
		if (wr_ptr >= cap)
			wr_ptr = 0;
		fill++;
	endfunction

	function automatic logic [7:0] ring_pop(int cap);
		logic [7:0] b;
		if (rd_ptr >= cap)
			rd_ptr = 0;
		b = ring_mem[rd_ptr];
		rd_ptr++;
		if (rd_ptr >= cap)
			rd_ptr = 0;
		fill--;
		return b;
	endfunction

	// Advance the ring by one request word and return the result it must give.
	function automatic fifo_result_t ring_step(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
			logic [DATA_W-1:0] wb);
		int cap;
		int room;
		int n;
		int i;
		fifo_result_t r;
		cap = eff_capacity();
		if (fill > cap)
			fill = cap;
		room = cap - fill;
		r = '0;
		case (op)
			OP_PUT_BYTE: begin
				if (room > 0) begin
					ring_push(wb[7:0], cap);
					r.ok = 1'b1;
					r.count = 4'd1;
				end
			end
			OP_GET_BYTE: begin
				if (fill > 0) begin
					r.read_bytes[7:0] = ring_pop(cap);
					r.ok = 1'b1;
					r.count = 4'd1;
				end
			end
			OP_PUT_BLOCK: begin
				if (int'(len) <= MAX_BURST && int'(len) <= room) begin
					for (i = 0; i < int'(len); i++)
						ring_push(wb[8*i +: 8], cap);
					r.ok = 1'b1;
					r.count = len;
				end
			end
			OP_GET_BLOCK: begin
				if (int'(len) <= MAX_BURST && int'(len) <= fill) begin
					for (i = 0; i < int'(len); i++)
						r.read_bytes[8*i +: 8] = ring_pop(cap);
					r.ok = 1'b1;
					r.count = len;
				end
			end
			OP_PUT_HEAD: begin
				if (int'(len) <= MAX_BURST) begin
					n = (int'(len) > room) ? room : int'(len);
					for (i = 0; i < n; i++)
						ring_push(wb[8*i +: 8], cap);
					r.ok = 1'b1;
					r.count = LEN_W'(n);
				end
			end
			default: ;
		endcase
		r.level = CAP_W'(fill);
		return r;
	endfunction

	// Present one request word after a random idle gap and hold it until accepted. The
	// expectation is queued in the step of the accept edge.
	task automatic send_word(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
			logic [DATA_W-1:0] wb, logic typed, fifo_result_t typed_res);
		int gap;
		fifo_result_t pred;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.op          <= op;
		req_ch.length      <= len;
		req_ch.write_bytes <= wb;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pred = ring_step(op, len, wb);
		pending_q.push_back(typed ? typed_res : pred);
	endtask

	// Drop valid and hold off until every expected result is back and the block takes
	// requests again; only then write the capacity. This is also the sender's pause.
	task automatic write_capacity(logic [CAP_W-1:0] v);
		req_ch.valid <= 1'b0;
		while (pending_q.size() != 0 || !req_ch.ready)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cap_reg = v;
		rd_ptr  = 0;
		wr_ptr  = 0;
		fill    = 0;
	endtask

	task automatic check_field(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (want !== got) begin
			err_cnt++;
			// keep the log bounded when the block is badly off
			if (err_cnt <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	// Receiver: stall at random with the current idle rate.
	always @(posedge clk)
		rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

	// Compare each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: result word with nothing expected, level %0d", $time,
						rsp_ch.level);
			end else begin
				head_res = pending_q.pop_front();
				check_field("ok", DATA_W'(head_res.ok), DATA_W'(rsp_ch.ok));
				check_field("count", DATA_W'(head_res.count), DATA_W'(rsp_ch.count));
				check_field("read_bytes", head_res.read_bytes, rsp_ch.read_bytes);
				check_field("level", DATA_W'(head_res.level), DATA_W'(rsp_ch.level));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int k;
		int p;
		int done;
		int total;
		int cap_v;
		bit fill_up;
		bit do_put;
		logic [OP_W-1:0]   op_v;
		logic [LEN_W-1:0]  len_v;
		logic [DATA_W-1:0] wb_v;

		req_ch.valid       <= 1'b0;
		req_ch.op          <= OP_PUT_BYTE;
		req_ch.length      <= '0;
		req_ch.write_bytes <= '0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: sender idles lightly, receiver stalls half the time.
		for (k = 0; k < $size(dir_tab); k++) begin
			if (dir_tab[k].kind == ROW_CFG)
				write_capacity(dir_tab[k].wdata[CAP_W-1:0]);
			else
				send_word(dir_tab[k].op, dir_tab[k].length, dir_tab[k].wdata,
					dir_tab[k].typed, dir_tab[k].res);
		end

		total   = 0;
		fill_up = 1'b1;
		for (p = 0; p < N_PHASES; p++) begin
			if (p == N_PHASES - 2)
				cap_v = $urandom_range(DEPTH, 1);
			else if (p == N_PHASES - 1)
				cap_v = $urandom_range((1 << CAP_W) - 1, 0);
			else
				cap_v = phase_cap[p];
			write_capacity(CAP_W'(cap_v));

			done = 0;
			while (done < phase_items[p]) begin
				// Idle pattern: sender light / receiver heavy, then swapped, then none.
				if (total < 480) begin
					tx_idle_pct = 18;
					rx_idle_pct = 50;
				end else if (total < 960) begin
					tx_idle_pct = 50;
					rx_idle_pct = 18;
				end else begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end

				// Sweep the fill level between empty and full: bias toward puts until
				// full, then toward gets until empty.
				if (fill >= eff_capacity())
					fill_up = 1'b0;
				else if (fill == 0)
					fill_up = 1'b1;

				if ($urandom_range(99) < 3) begin
					op_v = OP_W'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST));
				end else begin
					do_put = ($urandom_range(99) < (fill_up ? 80 : 20));
					if (do_put) begin
						case ($urandom_range(2))
							0: op_v = OP_PUT_BYTE;
							1: op_v = OP_PUT_BLOCK;
							default: op_v = OP_PUT_HEAD;
						endcase
					end else begin
						op_v = ($urandom_range(1) == 0) ? OP_GET_BYTE : OP_GET_BLOCK;
					end
				end

				if ($urandom_range(9) == 0)
					len_v = LEN_W'($urandom_range((1 << LEN_W) - 1, MAX_BURST + 1));
				else
					len_v = LEN_W'($urandom_range(MAX_BURST, 0));
				wb_v = {$urandom, $urandom};

				send_word(op_v, len_v, wb_v, 1'b0, NONE);
				total++;
				// rejected ops do not advance the phase
				if (op_v <= OP_PUT_HEAD)
					done++;
			end
		end

		// Drain: hold valid low until everything is back, then let the block settle.
		req_ch.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
